[sv/sha256_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha-256 shared definitions
// round constants, initial hash values, helper functions and common types
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam logic [7:0]  PAD_MARK    = 8'h80;

    // one block of work handed from the front end to the compression core
    typedef struct packed {
        logic [511:0] block;
        logic         last;   // final block of a message: emit digest afterwards
    } blk_req_t;

    typedef enum logic [1:0] {
        FE_ABSORB,
        FE_PAD_FULL,
        FE_PAD_LEN
    } fe_state_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_ADD,
        CORE_EMIT
    } core_state_t;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k [0:63];
        k = '{
            32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
            32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
            32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
            32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
            32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
            32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
            32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
            32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
            32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
            32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
            32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
            32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
            32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
            32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
            32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
            32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
        return k[t];
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h [0:7];
        h = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
              32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
        return h[i];
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

[sv/sha256_stream_hasher_unit.sv]
`timescale 1ns / 1ps
// compression core: a block is loaded, runs 64 rounds, then is added into the hash
// throughput: one byte per cycle while the queue has room and no padding is sent;
//   the core takes one block at a time, paced by the single shared round unit
// digest words follow the final block, one per cycle when m_tready is high
// reset: synchronous active-low aresetn restores the initial hash values and counts
// ----------------------------------------------------------------------------
// sha-256 stream hasher
// byte stream in, 256-bit digest out as four 64-bit big-endian words
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit #(
    parameter int unsigned QUEUE_DEPTH = sha256_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], byte_present[8], zeros
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // digest_word[63:0], word_index[65:64], zeros
    output logic        m_tlast    // last_word
);

    logic                 fq_valid, fq_ready, qc_valid, qc_ready;
    sha256_pkg::blk_req_t fq_data, qc_data;
    logic [63:0]          word;
    logic [1:0]           idx;

    sha256_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_byte(s_tdata[7:0]), .in_present(s_tdata[8]), .in_end(s_tlast),
        .blk_valid(fq_valid), .blk_ready(fq_ready), .blk_data(fq_data)
    );

    sha256_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
        .rd_valid(qc_valid), .rd_ready(qc_ready), .rd_data(qc_data)
    );

    sha256_core u_core (
        .aclk(aclk), .aresetn(aresetn),
        .req_valid(qc_valid), .req_ready(qc_ready), .req_data(qc_data),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_word(word), .out_index(idx), .out_last(m_tlast)
    );

    assign m_tdata = {6'd0, idx, word};

    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[65:64] == 2'd3)))
        else $error("last flag out of step with word index");

    a_idx_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid &&
            m_tdata[65:64] == $past(m_tdata[65:64]) + 2'd1))
        else $error("digest words not consecutive");

    a_no_lost_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (fq_valid && !fq_ready) |-> !s_tready)
        else $error("input taken while block queue full");

endmodule

[sv/sha256_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha-256 front end
// gathers bytes into 64-byte blocks, counts the bit length, builds padding
// ----------------------------------------------------------------------------
module sha256_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 in_present,
    input  logic                 in_end,
    output logic                 blk_valid,
    input  logic                 blk_ready,
    output sha256_pkg::blk_req_t blk_data
);

    sha256_pkg::fe_state_t state_reg, state_next;
    logic [511:0] buf_reg, buf_next;
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  bits_reg, bits_next;

    logic [511:0] buf_b;
    logic [5:0]   fill_b;
    logic [63:0]  bits_b;
    logic         full_b;
    logic [511:0] pad_buf;
    logic [511:0] len_buf;
    logic         accept;

    assign accept = in_valid && in_ready;

    always_comb begin
        in_ready = (state_reg == sha256_pkg::FE_ABSORB) && blk_ready;
    end

    // absorb the byte first
    always_comb begin
        buf_b  = buf_reg;
        fill_b = fill_reg;
        bits_b = bits_reg;
        full_b = 1'b0;
        if (in_present) begin
            buf_b[511 - 8 * fill_reg -: 8] = in_byte;
            bits_b = bits_reg + 64'd8;
            fill_b = fill_reg + 6'd1;
            full_b = (fill_reg == 6'd63);
        end
    end

    // mark byte then zeros after position fill_b
    always_comb begin
        pad_buf = buf_b;
        for (int i = 0; i < 64; i++) begin
            if (i == int'(fill_b)) begin
                pad_buf[511 - 8 * i -: 8] = sha256_pkg::PAD_MARK;
            end else if (i > int'(fill_b)) begin
                pad_buf[511 - 8 * i -: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        len_buf = buf_reg;
        len_buf[63:0] = bits_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sha256_pkg::FE_ABSORB: begin
                if (accept && in_end) begin
                    if (full_b) begin
                        state_next = sha256_pkg::FE_PAD_FULL;
                    end else if (fill_b > 6'd55) begin
                        state_next = sha256_pkg::FE_PAD_LEN;
                    end
                end
            end
            sha256_pkg::FE_PAD_FULL: begin
                if (blk_ready) begin
                    state_next = sha256_pkg::FE_ABSORB;
                end
            end
            sha256_pkg::FE_PAD_LEN: begin
                if (blk_ready) begin
                    state_next = sha256_pkg::FE_ABSORB;
                end
            end
            default: state_next = sha256_pkg::FE_ABSORB;
        endcase
    end

    always_comb begin
        buf_next   = buf_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        blk_valid  = 1'b0;
        blk_data   = '{block: buf_b, last: 1'b0};
        unique case (state_reg)
            sha256_pkg::FE_ABSORB: begin
                if (accept) begin
                    buf_next  = buf_b;
                    fill_next = fill_b;
                    bits_next = bits_b;
                    if (full_b) begin
                        blk_valid = 1'b1;
                        blk_data  = '{block: buf_b, last: 1'b0};
                    end
                    if (in_end) begin
                        if (full_b) begin
                            buf_next = {sha256_pkg::PAD_MARK, 504'd0};
                        end else if (fill_b > 6'd55) begin
                            blk_valid = 1'b1;
                            blk_data  = '{block: pad_buf, last: 1'b0};
                            buf_next  = 512'd0;
                        end else begin
                            blk_valid = 1'b1;
                            blk_data  = '{block: {pad_buf[511:64], bits_b}, last: 1'b1};
                            fill_next = 6'd0;
                            bits_next = 64'd0;
                        end
                    end
                end
            end
            sha256_pkg::FE_PAD_FULL, sha256_pkg::FE_PAD_LEN: begin
                blk_valid = 1'b1;
                blk_data  = '{block: len_buf, last: 1'b1};
                if (blk_ready) begin
                    fill_next = 6'd0;
                    bits_next = 64'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha256_pkg::FE_ABSORB;
            fill_reg  <= 6'd0;
            bits_reg  <= 64'd0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
        end
        buf_reg <= buf_next;
    end

endmodule

[sv/sha256_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha-256 block queue
// short fifo of block requests between front end and compression core
// ----------------------------------------------------------------------------
module sha256_queue #(
    parameter int unsigned DEPTH = sha256_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  sha256_pkg::blk_req_t wr_data,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output sha256_pkg::blk_req_t rd_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha256_pkg::blk_req_t mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          do_wr, do_rd;

    assign wr_ready = (cnt_reg != AW'(0) + (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_wr) begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            end
            if (do_rd) begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
        end
        if (do_wr) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule

[sv/sha256_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha-256 compression core
// one round per cycle with a rolling 16-word schedule, emits the digest
// ----------------------------------------------------------------------------
module sha256_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  sha256_pkg::blk_req_t req_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [63:0]          out_word,
    output logic [1:0]           out_index,
    output logic                 out_last
);

    sha256_pkg::core_state_t state_reg, state_next;
    logic [31:0] h_reg [8];
    logic [31:0] r_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  t_reg;
    logic        last_reg;
    logic [1:0]  k_reg;

    logic [31:0] s0w, s1w, wnew, s1, ch, t1, s0, mj;

    always_comb begin
        s0w  = sha256_pkg::ror32(w_reg[1], 7) ^ sha256_pkg::ror32(w_reg[1], 18)
             ^ (w_reg[1] >> 3);
        s1w  = sha256_pkg::ror32(w_reg[14], 17) ^ sha256_pkg::ror32(w_reg[14], 19)
             ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0w + w_reg[9] + s1w;
        s1   = sha256_pkg::ror32(r_reg[4], 6) ^ sha256_pkg::ror32(r_reg[4], 11)
             ^ sha256_pkg::ror32(r_reg[4], 25);
        ch   = (r_reg[4] & r_reg[5]) ^ (~r_reg[4] & r_reg[6]);
        t1   = r_reg[7] + s1 + ch + sha256_pkg::round_k(t_reg) + w_reg[0];
        s0   = sha256_pkg::ror32(r_reg[0], 2) ^ sha256_pkg::ror32(r_reg[0], 13)
             ^ sha256_pkg::ror32(r_reg[0], 22);
        mj   = (r_reg[0] & r_reg[1]) ^ (r_reg[0] & r_reg[2]) ^ (r_reg[1] & r_reg[2]);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sha256_pkg::CORE_IDLE:  if (req_valid) state_next = sha256_pkg::CORE_ROUND;
            sha256_pkg::CORE_ROUND: if (t_reg == 6'd63) state_next = sha256_pkg::CORE_ADD;
            sha256_pkg::CORE_ADD: begin
                state_next = last_reg ? sha256_pkg::CORE_EMIT : sha256_pkg::CORE_IDLE;
            end
            sha256_pkg::CORE_EMIT: begin
                if (out_ready && k_reg == 2'd3) state_next = sha256_pkg::CORE_IDLE;
            end
            default: state_next = sha256_pkg::CORE_IDLE;
        endcase
    end

    always_comb begin
        req_ready = (state_reg == sha256_pkg::CORE_IDLE);
        out_valid = (state_reg == sha256_pkg::CORE_EMIT);
        out_word  = {h_reg[{k_reg, 1'b0}], h_reg[{k_reg, 1'b1}]};
        out_index = k_reg;
        out_last  = (k_reg == 2'd3);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha256_pkg::CORE_IDLE;
            t_reg     <= 6'd0;
            k_reg     <= 2'd0;
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= sha256_pkg::init_h(3'(i));
            end
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                sha256_pkg::CORE_IDLE: begin
                    t_reg <= 6'd0;
                    k_reg <= 2'd0;
                end
                sha256_pkg::CORE_ROUND: t_reg <= t_reg + 6'd1;
                sha256_pkg::CORE_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        h_reg[i] <= h_reg[i] + r_reg[i];
                    end
                end
                sha256_pkg::CORE_EMIT: begin
                    if (out_ready) begin
                        k_reg <= k_reg + 2'd1;
                        // digest gone: back to the initial hash values
                        if (k_reg == 2'd3) begin
                            for (int i = 0; i < 8; i++) begin
                                h_reg[i] <= sha256_pkg::init_h(3'(i));
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        if (state_reg == sha256_pkg::CORE_IDLE && req_valid) begin
            last_reg <= req_data.last;
            for (int i = 0; i < 16; i++) begin
                w_reg[i] <= req_data.block[511 - 32 * i -: 32];
            end
            for (int i = 0; i < 8; i++) begin
                r_reg[i] <= h_reg[i];
            end
        end else if (state_reg == sha256_pkg::CORE_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= wnew;
            r_reg[7] <= r_reg[6];
            r_reg[6] <= r_reg[5];
            r_reg[5] <= r_reg[4];
            r_reg[4] <= r_reg[3] + t1;
            r_reg[3] <= r_reg[2];
            r_reg[2] <= r_reg[1];
            r_reg[1] <= r_reg[0];
            r_reg[0] <= t1 + s0 + mj;
        end
    end

endmodule
